@@ hdl/probabilistic_cvt_center_update_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the CVT center update block
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef PROBABILISTIC_CVT_CENTER_UPDATE_TOP_ASSERT_SVH
`define PROBABILISTIC_CVT_CENTER_UPDATE_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PCVT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PCVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pcvt_pkg.sv @@
// ----------------------------------------------------------------------------
// pcvt_pkg
// Shared widths, codes and handshake types of the CVT center update block.
// ----------------------------------------------------------------------------
package pcvt_pkg;

    localparam int COORD_W    = 20;
    localparam int COUNT_W    = 16;
    localparam int SUM_W      = 37;
    localparam int IMG_W      = 22;
    localparam int EXT_W      = 19;
    localparam int GCFG_W     = 17;
    localparam int GAIN_W     = 33;
    localparam int GAIN_FRAC  = 16;
    localparam int SQ_W       = 40;
    localparam int DIST_W     = 41;
    localparam int BLEND_W    = 57;
    localparam int MEAN_W     = 22;
    localparam int MAG_W      = 30;
    localparam int ACC_W      = 2 * SUM_W + COUNT_W;
    localparam int SLOT_W     = 10;
    localparam int ACTIVE_W   = 11;
    localparam int MOVED_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int WRAP_W     = 2;

    localparam int DIV_NW = 58;
    localparam int DIV_DW = 33;
    localparam int DIV_CW = 6;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OLD_SLOPE = 3'd0,
        CFG_OLD_BASE  = 3'd1,
        CFG_NEW_SLOPE = 3'd2,
        CFG_NEW_BASE  = 3'd3,
        CFG_WIDTH     = 3'd4,
        CFG_HEIGHT    = 3'd5,
        CFG_WRAP      = 3'd6,
        CFG_ACTIVE    = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_SCAN,
        ST_S_ACC_RD,
        ST_S_ACC_WR,
        ST_U_RD,
        ST_U_CHK,
        ST_U_GAIN,
        ST_U_MX_GO,
        ST_U_MX_WT,
        ST_U_MY_GO,
        ST_U_MY_WT,
        ST_U_BL_MUL,
        ST_U_BL_SUM,
        ST_U_NX_GO,
        ST_U_NX_WT,
        ST_U_NY_GO,
        ST_U_NY_WT,
        ST_U_WB
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } div_rsp_t;

endpackage

@@ hdl/pcvt_ram.sv @@
// ----------------------------------------------------------------------------
// pcvt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/pcvt_div.sv @@
// ----------------------------------------------------------------------------
// pcvt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcvt_div
    import pcvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_NW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift one dividend bit into the remainder per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

@@ hdl/probabilistic_cvt_center_update_top.sv @@
// ----------------------------------------------------------------------------
// probabilistic_cvt_center_update_top
// Table of 2-D Voronoi centers with nearest-center search, per-center sample
// accumulation and a weighted blend of old position and sample mean.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  command   start / busy         kind, slot, point_x, point_y
//  result    done (1-cycle beat)  center_index, found, center_x, center_y,
//                                 center_weight, moved_count
//  config    cfg_we               cfg_index, cfg_data
//
//  A load is done from idle, a read after the registered RAM read. A sample
//  scans the position RAM one center per cycle through a 3-stage distance
//  pipeline over the active centers. An update sweeps all MAX_CENTERS
//  entries; a hit one uses the shared bit-serial divider, others are cleared.
//  After reset a clearing pass over all MAX_CENTERS entries sets sums and
//  counts to zero and round weights to one; busy is high meanwhile. One
//  command is in flight at a time; the receiver cannot stall a beat.
//
module probabilistic_cvt_center_update_top
    import pcvt_pkg::*;
#(
    parameter int MAX_CENTERS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic [SLOT_W-1:0]            slot,
    input  logic signed [COORD_W-1:0]    point_x,
    input  logic signed [COORD_W-1:0]    point_y,
    output logic                         done,
    output logic [SLOT_W-1:0]            center_index,
    output logic                         found,
    output logic signed [COORD_W-1:0]    center_x,
    output logic signed [COORD_W-1:0]    center_y,
    output logic [COUNT_W-1:0]           center_weight,
    output logic [MOVED_W-1:0]           moved_count,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int AW    = $clog2(MAX_CENTERS);
    localparam int CNT_W = (AW + 1 > ACTIVE_W) ? AW + 1 : ACTIVE_W;
    localparam logic [CNT_W-1:0]   MAX_N     = CNT_W'(MAX_CENTERS);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic signed [MAG_W+2:0] COORD_HI = (MAG_W+3)'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [MAG_W+2:0] COORD_LO = -(MAG_W+3)'(1 << (COORD_W - 1));

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // Minimum-image shift for one periodic axis.
    function automatic logic signed [IMG_W-1:0] min_image(
        input logic signed [COORD_W:0] d,
        input logic [EXT_W-1:0]        ext,
        input logic                    per
    );
        logic signed [IMG_W-1:0] d2;
        logic signed [IMG_W-1:0] e;
        d2 = {IMG_W'(d)} <<< 1;
        e  = $signed({{(IMG_W - EXT_W){1'b0}}, ext});
        if (per && (d2 > e))
            return -e;
        else if (per && (d2 < -e))
            return e;
        else
            return '0;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W:0] hi;
        logic signed [SUM_W:0] lo;
        hi = (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
        lo = -hi - (SUM_W+1)'(1);
        if (v > hi)
            return hi[SUM_W-1:0];
        else if (v < lo)
            return lo[SUM_W-1:0];
        else
            return v[SUM_W-1:0];
    endfunction

    // Wrap once on a periodic axis, then saturate to the coordinate range.
    function automatic logic signed [COORD_W-1:0] wrap_clamp(
        input logic signed [MAG_W+1:0] v,
        input logic [EXT_W-1:0]        ext,
        input logic                    per
    );
        logic signed [MAG_W+2:0] t;
        logic signed [MAG_W+2:0] e;
        t = (MAG_W+3)'(v);
        e = $signed({{(MAG_W + 3 - EXT_W){1'b0}}, ext});
        if (per && (t < 0))
            t = t + e;
        else if (per && (t >= e))
            t = t - e;
        if (t > COORD_HI)
            t = COORD_HI;
        else if (t < COORD_LO)
            t = COORD_LO;
        return t[COORD_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [GCFG_W-1:0]   old_slope_reg, old_base_reg, new_slope_reg, new_base_reg;
    logic [EXT_W-1:0]    width_reg, height_reg;
    logic [WRAP_W-1:0]   wrap_reg;
    logic [ACTIVE_W-1:0] active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_slope_reg <= GCFG_W'(32768);
            old_base_reg  <= '0;
            new_slope_reg <= GCFG_W'(32768);
            new_base_reg  <= GCFG_W'(65536);
            width_reg     <= EXT_W'(65536);
            height_reg    <= EXT_W'(65536);
            wrap_reg      <= '0;
            active_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_OLD_SLOPE: old_slope_reg <= cfg_data[GCFG_W-1:0];
                CFG_OLD_BASE:  old_base_reg  <= cfg_data[GCFG_W-1:0];
                CFG_NEW_SLOPE: new_slope_reg <= cfg_data[GCFG_W-1:0];
                CFG_NEW_BASE:  new_base_reg  <= cfg_data[GCFG_W-1:0];
                CFG_WIDTH:     width_reg     <= cfg_data[EXT_W-1:0];
                CFG_HEIGHT:    height_reg    <= cfg_data[EXT_W-1:0];
                CFG_WRAP:      wrap_reg      <= cfg_data[WRAP_W-1:0];
                CFG_ACTIVE:    active_reg    <= cfg_data[ACTIVE_W-1:0];
                default:       ;
            endcase
        end
    end

    logic             per_x, per_y;
    logic [CNT_W-1:0] n_lim;

    // clamp the active count to the table depth
    assign per_x = wrap_reg[0];
    assign per_y = wrap_reg[1];
    assign n_lim = (CNT_W'(active_reg) > MAX_N) ? MAX_N : CNT_W'(active_reg);

    // ------------------------------------------------------------------
    // memories: positions, round weights, accumulators {sum_x, sum_y, hits}
    // ------------------------------------------------------------------
    logic                   pos_we, wgt_we, acc_we;
    logic [AW-1:0]          pos_waddr, pos_raddr, wgt_waddr, wgt_raddr, acc_waddr, acc_raddr;
    logic [2*COORD_W-1:0]   pos_wdata, pos_rdata;
    logic [COUNT_W-1:0]     wgt_wdata, wgt_rdata;
    logic [ACC_W-1:0]       acc_wdata, acc_rdata;

    pcvt_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_CENTERS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    pcvt_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_CENTERS)) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (wgt_wdata),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    pcvt_ram #(.WIDTH(ACC_W), .DEPTH(MAX_CENTERS)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // ------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------
    div_req_t div_req;
    div_rsp_t div_rsp;

    pcvt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;

    // search pipeline
    logic v1_reg, v1_next, v2_reg, v3_reg;
    logic [AW-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic signed [IMG_W-1:0] adx2_reg, ady2_reg, imgx2_reg, imgy2_reg;
    logic signed [IMG_W-1:0] imgx3_reg, imgy3_reg;
    logic [SQ_W-1:0] sqx3_reg, sqy3_reg;
    logic have_reg, have_next;
    logic [AW-1:0] best_reg, best_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic signed [IMG_W-1:0] best_imgx_reg, best_imgx_next, best_imgy_reg, best_imgy_next;

    // update datapath
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [COUNT_W-1:0] j_reg, j_next, hit_reg, hit_next;
    logic signed [SUM_W-1:0] sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [GAIN_W-1:0] go_reg, go_next, gn_reg, gn_next;
    logic signed [MEAN_W-1:0] ux_reg, ux_next, uy_reg, uy_next;
    logic signed [BLEND_W-1:0] pox_reg, pox_next, pnx_reg, pnx_next;
    logic signed [BLEND_W-1:0] poy_reg, poy_next, pny_reg, pny_next;
    logic signed [BLEND_W-1:0] numx_reg, numx_next, numy_reg, numy_next;
    logic signed [COORD_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic neg_reg, neg_next;
    logic [MOVED_W-1:0] moved_reg, moved_next;

    // result beat
    logic done_reg, done_next;
    logic [SLOT_W-1:0] res_index_reg, res_index_next;
    logic res_found_reg, res_found_next;
    logic signed [COORD_W-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [COUNT_W-1:0] res_w_reg, res_w_next;
    logic [MOVED_W-1:0] res_moved_reg, res_moved_next;

    // ------------------------------------------------------------------
    // search stage 1: offset with minimum image
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] cx1, cy1;
    logic signed [COORD_W:0]   dx1, dy1;
    logic signed [IMG_W-1:0]   sx1, sy1;
    logic signed [2*IMG_W-1:0] sqx_full, sqy_full;
    logic [DIST_W-1:0]         d3;

    always_comb
    begin
        cx1      = pos_rdata[2*COORD_W-1:COORD_W];
        cy1      = pos_rdata[COORD_W-1:0];
        dx1      = (COORD_W+1)'(px_reg) - (COORD_W+1)'(cx1);
        dy1      = (COORD_W+1)'(py_reg) - (COORD_W+1)'(cy1);
        sx1      = min_image(dx1, width_reg, per_x);
        sy1      = min_image(dy1, height_reg, per_y);
        sqx_full = (2*IMG_W)'(adx2_reg) * (2*IMG_W)'(adx2_reg);
        sqy_full = (2*IMG_W)'(ady2_reg) * (2*IMG_W)'(ady2_reg);
        d3       = DIST_W'(sqx3_reg) + DIST_W'(sqy3_reg);
    end

    always_ff @(posedge clk)
    begin
        idx1_reg  <= pos_raddr;
        idx2_reg  <= idx1_reg;
        adx2_reg  <= IMG_W'(dx1) + sx1;
        ady2_reg  <= IMG_W'(dy1) + sy1;
        imgx2_reg <= IMG_W'(px_reg) + sx1;
        imgy2_reg <= IMG_W'(py_reg) + sy1;
        idx3_reg  <= idx2_reg;
        sqx3_reg  <= sqx_full[SQ_W-1:0];
        sqy3_reg  <= sqy_full[SQ_W-1:0];
        imgx3_reg <= imgx2_reg;
        imgy3_reg <= imgy2_reg;
    end

    // ------------------------------------------------------------------
    // divider operand prep: magnitude plus half the divisor, sign kept aside
    // ------------------------------------------------------------------
    logic signed [BLEND_W-1:0] dn_num;
    logic [DIV_DW-1:0]         dn_den;
    logic [BLEND_W-1:0]        dn_mag;
    logic [MEAN_W-1:0]         q_mean;
    logic signed [MEAN_W-1:0]  mean_s;
    logic [MAG_W-1:0]          q_sat;
    logic signed [MAG_W+1:0]   blend_s;
    logic [DIV_DW-1:0]         den_blend;

    always_comb
    begin
        den_blend = {(COUNT_W+1)'(j_reg) + (COUNT_W+1)'(1), {GAIN_FRAC{1'b0}}};
        dn_mag    = dn_num[BLEND_W-1] ? BLEND_W'(-dn_num) : BLEND_W'(dn_num);
        q_mean    = div_rsp.quot[MEAN_W-1:0];
        mean_s    = neg_reg ? -$signed(q_mean) : $signed(q_mean);
        q_sat     = (|div_rsp.quot[DIV_NW-1:MAG_W]) ? {MAG_W{1'b1}}
                                                    : div_rsp.quot[MAG_W-1:0];
        blend_s   = neg_reg ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
    end

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    logic               slot_ok_in, slot_ok_reg;
    logic [CNT_W-1:0]   slot_in_ext;
    logic [AW-1:0]      slot_in_addr;
    logic signed [SUM_W-1:0] accx_new, accy_new;
    logic [COUNT_W-1:0] acc_hit_rd;
    logic               u_advance;

    assign slot_in_ext  = CNT_W'(slot);
    assign slot_in_addr = slot_in_ext[AW-1:0];
    assign slot_ok_in   = (slot_in_ext < MAX_N);
    assign slot_ok_reg  = (slot_reg < MAX_N);
    assign acc_hit_rd   = acc_rdata[COUNT_W-1:0];

    always_comb
    begin
        accx_new = sat_sum((SUM_W+1)'($signed(acc_rdata[ACC_W-1:ACC_W-SUM_W]))
                           + (SUM_W+1)'(best_imgx_reg));
        accy_new = sat_sum((SUM_W+1)'($signed(acc_rdata[ACC_W-SUM_W-1:COUNT_W]))
                           + (SUM_W+1)'(best_imgy_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        v1_next        = 1'b0;
        have_next      = have_reg;
        best_next      = best_reg;
        best_d_next    = best_d_reg;
        best_imgx_next = best_imgx_reg;
        best_imgy_next = best_imgy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        j_next         = j_reg;
        hit_next       = hit_reg;
        sumx_next      = sumx_reg;
        sumy_next      = sumy_reg;
        go_next        = go_reg;
        gn_next        = gn_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        pox_next       = pox_reg;
        pnx_next       = pnx_reg;
        poy_next       = poy_reg;
        pny_next       = pny_reg;
        numx_next      = numx_reg;
        numy_next      = numy_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        neg_next       = neg_reg;
        moved_next     = moved_reg;
        done_next      = 1'b0;
        res_index_next = res_index_reg;
        res_found_next = res_found_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_w_next     = res_w_reg;
        res_moved_next = res_moved_reg;
        u_advance      = 1'b0;

        pos_we    = 1'b0;
        pos_waddr = idx_reg[AW-1:0];
        pos_wdata = {nx_reg, ny_reg};
        pos_raddr = idx_reg[AW-1:0];
        wgt_we    = 1'b0;
        wgt_waddr = idx_reg[AW-1:0];
        wgt_wdata = (j_reg == COUNT_MAX) ? j_reg : j_reg + COUNT_W'(1);
        wgt_raddr = idx_reg[AW-1:0];
        acc_we    = 1'b0;
        acc_waddr = idx_reg[AW-1:0];
        acc_wdata = '0;
        acc_raddr = idx_reg[AW-1:0];

        dn_num    = BLEND_W'(sumx_reg);
        dn_den    = DIV_DW'(hit_reg);
        div_req.start = 1'b0;

        // search stage 3: strict less-than keeps the lowest index on a tie
        if (v3_reg && (!have_reg || (d3 < best_d_reg)))
        begin
            have_next      = 1'b1;
            best_next      = idx3_reg;
            best_d_next    = d3;
            best_imgx_next = imgx3_reg;
            best_imgy_next = imgy3_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                acc_we    = 1'b1;
                wgt_we    = 1'b1;
                wgt_wdata = COUNT_W'(1);
                if (idx_reg == MAX_N - CNT_W'(1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    px_next   = point_x;
                    py_next   = point_y;
                    slot_next = slot_in_ext;
                    res_index_next = '0;
                    res_found_next = 1'b0;
                    res_x_next     = '0;
                    res_y_next     = '0;
                    res_w_next     = '0;
                    res_moved_next = '0;
                    case (kind_t'(kind))
                        KIND_LOAD:
                        begin
                            pos_we         = slot_ok_in;
                            pos_waddr      = slot_in_addr;
                            pos_wdata      = {point_x, point_y};
                            res_index_next = slot;
                            done_next      = 1'b1;
                        end
                        KIND_SAMPLE:
                        begin
                            if (n_lim == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                have_next  = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_UPDATE:
                        begin
                            idx_next   = '0;
                            moved_next = '0;
                            state_next = ST_U_RD;
                        end
                        KIND_READ:
                        begin
                            pos_raddr  = slot_in_addr;
                            wgt_raddr  = slot_in_addr;
                            state_next = ST_RD;
                        end
                        default: ;
                    endcase
                end
            end

            ST_RD:
            begin
                res_index_next = SLOT_W'(slot_reg);
                if (slot_ok_reg)
                begin
                    res_x_next = pos_rdata[2*COORD_W-1:COORD_W];
                    res_y_next = pos_rdata[COORD_W-1:0];
                    res_w_next = wgt_rdata;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                // issue one center per cycle, then drain the pipe
                if (idx_reg < n_lim)
                begin
                    v1_next  = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                else if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_S_ACC_RD;
                end
            end

            ST_S_ACC_RD:
            begin
                acc_raddr  = best_reg;
                state_next = ST_S_ACC_WR;
            end

            ST_S_ACC_WR:
            begin
                // a full hit count drops the sample from the sums
                if (acc_hit_rd != COUNT_MAX)
                begin
                    acc_we    = 1'b1;
                    acc_waddr = best_reg;
                    acc_wdata = {accx_new, accy_new, acc_hit_rd + COUNT_W'(1)};
                end
                res_index_next = SLOT_W'(best_reg);
                res_found_next = 1'b1;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_U_RD:
            begin
                state_next = ST_U_CHK;
            end

            ST_U_CHK:
            begin
                cx_next   = pos_rdata[2*COORD_W-1:COORD_W];
                cy_next   = pos_rdata[COORD_W-1:0];
                j_next    = wgt_rdata;
                sumx_next = acc_rdata[ACC_W-1:ACC_W-SUM_W];
                sumy_next = acc_rdata[ACC_W-SUM_W-1:COUNT_W];
                hit_next  = acc_hit_rd;
                if ((idx_reg < n_lim) && (acc_hit_rd != '0))
                begin
                    state_next = ST_U_GAIN;
                end
                else
                begin
                    acc_we    = 1'b1;
                    u_advance = 1'b1;
                end
            end

            ST_U_GAIN:
            begin
                go_next = GAIN_W'(old_slope_reg) * GAIN_W'(j_reg) + GAIN_W'(old_base_reg);
                gn_next = GAIN_W'(new_slope_reg) * GAIN_W'(j_reg) + GAIN_W'(new_base_reg);
                state_next = ST_U_MX_GO;
            end

            ST_U_MX_GO:
            begin
                dn_num        = BLEND_W'(sumx_reg);
                dn_den        = DIV_DW'(hit_reg);
                div_req.start = 1'b1;
                neg_next      = dn_num[BLEND_W-1];
                state_next    = ST_U_MX_WT;
            end

            ST_U_MX_WT:
            begin
                if (div_rsp.done)
                begin
                    ux_next    = mean_s;
                    state_next = ST_U_MY_GO;
                end
            end

            ST_U_MY_GO:
            begin
                dn_num        = BLEND_W'(sumy_reg);
                dn_den        = DIV_DW'(hit_reg);
                div_req.start = 1'b1;
                neg_next      = dn_num[BLEND_W-1];
                state_next    = ST_U_MY_WT;
            end

            ST_U_MY_WT:
            begin
                if (div_rsp.done)
                begin
                    uy_next    = mean_s;
                    state_next = ST_U_BL_MUL;
                end
            end

            ST_U_BL_MUL:
            begin
                pox_next   = BLEND_W'($signed({1'b0, go_reg})) * BLEND_W'(cx_reg);
                pnx_next   = BLEND_W'($signed({1'b0, gn_reg})) * BLEND_W'(ux_reg);
                poy_next   = BLEND_W'($signed({1'b0, go_reg})) * BLEND_W'(cy_reg);
                pny_next   = BLEND_W'($signed({1'b0, gn_reg})) * BLEND_W'(uy_reg);
                state_next = ST_U_BL_SUM;
            end

            ST_U_BL_SUM:
            begin
                numx_next  = pox_reg + pnx_reg;
                numy_next  = poy_reg + pny_reg;
                state_next = ST_U_NX_GO;
            end

            ST_U_NX_GO:
            begin
                dn_num        = numx_reg;
                dn_den        = den_blend;
                div_req.start = 1'b1;
                neg_next      = dn_num[BLEND_W-1];
                state_next    = ST_U_NX_WT;
            end

            ST_U_NX_WT:
            begin
                if (div_rsp.done)
                begin
                    nx_next    = wrap_clamp(blend_s, width_reg, per_x);
                    state_next = ST_U_NY_GO;
                end
            end

            ST_U_NY_GO:
            begin
                dn_num        = numy_reg;
                dn_den        = den_blend;
                div_req.start = 1'b1;
                neg_next      = dn_num[BLEND_W-1];
                state_next    = ST_U_NY_WT;
            end

            ST_U_NY_WT:
            begin
                if (div_rsp.done)
                begin
                    ny_next    = wrap_clamp(blend_s, height_reg, per_y);
                    state_next = ST_U_WB;
                end
            end

            ST_U_WB:
            begin
                pos_we     = 1'b1;
                wgt_we     = 1'b1;
                acc_we     = 1'b1;
                moved_next = moved_reg + MOVED_W'(1);
                u_advance  = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next entry, or close the sweep with the result beat
        if (u_advance)
        begin
            if (idx_reg == MAX_N - CNT_W'(1))
            begin
                res_moved_next = moved_next;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end
            else
            begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_U_RD;
            end
        end

        div_req.num = DIV_NW'(dn_mag) + DIV_NW'(dn_den >> 1);
        div_req.den = dn_den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            have_reg  <= 1'b0;
            done_reg  <= 1'b0;
            moved_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            v1_reg    <= v1_next;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            have_reg  <= have_next;
            done_reg  <= done_next;
            moved_reg <= moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        best_reg      <= best_next;
        best_d_reg    <= best_d_next;
        best_imgx_reg <= best_imgx_next;
        best_imgy_reg <= best_imgy_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        j_reg         <= j_next;
        hit_reg       <= hit_next;
        sumx_reg      <= sumx_next;
        sumy_reg      <= sumy_next;
        go_reg        <= go_next;
        gn_reg        <= gn_next;
        ux_reg        <= ux_next;
        uy_reg        <= uy_next;
        pox_reg       <= pox_next;
        pnx_reg       <= pnx_next;
        poy_reg       <= poy_next;
        pny_reg       <= pny_next;
        numx_reg      <= numx_next;
        numy_reg      <= numy_next;
        nx_reg        <= nx_next;
        ny_reg        <= ny_next;
        neg_reg       <= neg_next;
        res_index_reg <= res_index_next;
        res_found_reg <= res_found_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_w_reg     <= res_w_next;
        res_moved_reg <= res_moved_next;
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign center_index  = res_index_reg;
    assign found         = res_found_reg;
    assign center_x      = res_x_reg;
    assign center_y      = res_y_reg;
    assign center_weight = res_w_reg;
    assign moved_count   = res_moved_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "probabilistic_cvt_center_update_top_assert.svh"

    `PCVT_ASSERT_SAME(a_found_in_range, done_reg && res_found_reg, CNT_W'(res_index_reg) < n_lim, "nearest center beyond active count")
    `PCVT_ASSERT_SAME(a_beat_has_cause, done_reg, ($past(state_reg) != ST_IDLE) || $past(start), "result beat without a command")
    `PCVT_ASSERT_SAME(a_pipe_drained, state_reg == ST_S_ACC_RD, !v1_reg && !v2_reg && !v3_reg, "search left before pipe drained")
    `PCVT_ASSERT_NEXT(a_moved_counts, state_reg == ST_U_WB, moved_reg == $past(moved_reg) + MOVED_W'(1), "moved count missed a write-back")

endmodule

@@ bench/probabilistic_cvt_center_update_top_tb.sv @@
// ----------------------------------------------------------------------------
// probabilistic_cvt_center_update_top_tb
// Self-checking bench for the CVT center update block. Every command beat is
// mirrored by a behavioral copy of the center table. The copy, or a typed row,
// gives the expected result beat, and a monitor compares each done beat with the
// oldest expectation, field by field. A short directed table is followed by a full
// preload of the center table, a directed two-center round and then a series
// of register settings with random commands.
// ----------------------------------------------------------------------------
module probabilistic_cvt_center_update_top_tb;
    import pcvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CENTERS   = 1024;
    localparam int STALL_LIMIT = 300000;
    localparam longint COORD_HI = 524287;
    localparam longint COORD_LO = -524288;
    localparam longint SUM_HI   = (64'sd1 <<< 36) - 1;
    localparam longint SUM_LO   = -(64'sd1 <<< 36);
    localparam longint GAIN_CAP = (64'sd1 <<< 34) - 1;
    localparam int HITS_MAX    = 65535;

    typedef struct packed {
        logic [SLOT_W-1:0]         index;
        logic                      found;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [COUNT_W-1:0]        weight;
        logic [MOVED_W-1:0]        moved;
    } center_beat_t;

    typedef struct packed {
        kind_t                     kind;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      typed;
        center_beat_t              want;
    } cmd_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                kind = KIND_LOAD;
    logic [SLOT_W-1:0]         slot = '0;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic                      done;
    logic [SLOT_W-1:0]         center_index;
    logic                      found;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [COUNT_W-1:0]        center_weight;
    logic [MOVED_W-1:0]        moved_count;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = CFG_OLD_SLOPE;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    probabilistic_cvt_center_update_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .slot(slot), .point_x(point_x), .point_y(point_y),
        .done(done), .center_index(center_index), .found(found),
        .center_x(center_x), .center_y(center_y), .center_weight(center_weight),
        .moved_count(moved_count),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow of the block's registers and center table.
    longint old_slope, old_base, new_slope, new_base;
    longint dom_w, dom_h, wrap_bits, active_cnt;
    longint pos_x [N_CENTERS];
    longint pos_y [N_CENTERS];
    longint acc_x [N_CENTERS];
    longint acc_y [N_CENTERS];
    int     hits  [N_CENTERS];
    int     rounds[N_CENTERS];

    center_beat_t pending_beats[$];
    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  samples_found = 0;
    int  centers_moved = 0;
    int  stall_cycles = 0;
    int  send_idle_pct = 21;

    function automatic longint clamp_to(longint v, longint hi, longint lo);
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Round to nearest, halves away from zero.
    function automatic longint round_div(longint n, longint d);
        longint mag;
        longint q;
        mag = n < 0 ? -n : n;
        q = (mag + d / 2) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic longint image_shift(longint d, longint ext, bit periodic);
        if (!periodic)
            return 0;
        if (2 * d > ext)
            return -ext;
        if (2 * d < -ext)
            return ext;
        return 0;
    endfunction

    function automatic longint wrap_axis(longint v, longint ext, bit periodic);
        if (periodic)
        begin
            if (v < 0)
                v = v + ext;
            else if (v >= ext)
                v = v - ext;
        end
        return clamp_to(v, COORD_HI, COORD_LO);
    endfunction

    function automatic longint blend_gain(longint slope_q, longint base_q, longint j);
        longint g;
        g = slope_q * j + base_q;
        return g > GAIN_CAP ? GAIN_CAP : g;
    endfunction

    // Advance the shadow table by one command and return the beat it yields.
    function automatic center_beat_t step_center_table(kind_t k, int s, longint px,
                                                       longint py);
        center_beat_t r;
        int     n;
        int     best;
        bit     have;
        longint best_d, dx, dy, sx, sy, d, ix, iy, ux, uy, go, gn, den, nx, ny;
        int     moved;
        r = '0;
        n = active_cnt > N_CENTERS ? N_CENTERS : int'(active_cnt);
        case (k)
            KIND_LOAD:
            begin
                r.index = s;
                pos_x[s] = px;
                pos_y[s] = py;
            end
            KIND_SAMPLE:
            begin
                have = 0;
                best = 0;
                best_d = 0;
                ix = px;
                iy = py;
                for (int i = 0; i < n; i++)
                begin
                    dx = px - pos_x[i];
                    dy = py - pos_y[i];
                    sx = image_shift(dx, dom_w, wrap_bits[0]);
                    sy = image_shift(dy, dom_h, wrap_bits[1]);
                    dx = dx + sx;
                    dy = dy + sy;
                    d = dx * dx + dy * dy;
                    if (!have || d < best_d)
                    begin
                        have = 1;
                        best = i;
                        best_d = d;
                        ix = px + sx;
                        iy = py + sy;
                    end
                end
                if (have)
                begin
                    r.index = best;
                    r.found = 1'b1;
                    if (hits[best] < HITS_MAX)
                    begin
                        acc_x[best] = clamp_to(acc_x[best] + ix, SUM_HI, SUM_LO);
                        acc_y[best] = clamp_to(acc_y[best] + iy, SUM_HI, SUM_LO);
                        hits[best]++;
                    end
                end
            end
            KIND_UPDATE:
            begin
                moved = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (hits[i] == 0)
                        continue;
                    ux = round_div(acc_x[i], hits[i]);
                    uy = round_div(acc_y[i], hits[i]);
                    go = blend_gain(old_slope, old_base, rounds[i]);
                    gn = blend_gain(new_slope, new_base, rounds[i]);
                    den = (longint'(rounds[i]) + 1) << 16;
                    nx = round_div(go * pos_x[i] + gn * ux, den);
                    ny = round_div(go * pos_y[i] + gn * uy, den);
                    pos_x[i] = wrap_axis(nx, dom_w, wrap_bits[0]);
                    pos_y[i] = wrap_axis(ny, dom_h, wrap_bits[1]);
                    if (rounds[i] < HITS_MAX)
                        rounds[i]++;
                    moved++;
                end
                for (int i = 0; i < N_CENTERS; i++)
                begin
                    acc_x[i] = 0;
                    acc_y[i] = 0;
                    hits[i] = 0;
                end
                r.moved = moved;
            end
            default:
            begin
                r.index = s;
                r.cx = pos_x[s];
                r.cy = pos_y[s];
                r.weight = rounds[s];
            end
        endcase
        return r;
    endfunction

    // Drive one command beat and hold it until the block takes it.
    task automatic issue_command(kind_t k, int s, longint px, longint py, bit typed,
                                 center_beat_t want);
        center_beat_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start   <= 1'b1;
        kind    <= k;
        slot    <= s;
        point_x <= px;
        point_y <= py;
        do
            @(posedge clk);
        while (busy);
        predicted = step_center_table(k, s, px, py);
        pending_beats.push_back(typed ? want : predicted);
        beats_in++;
    endtask

    // Let the block drain, then write one register.
    task automatic write_register(cfg_idx_t idx, longint value);
        start <= 1'b0;
        while (pending_beats.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_OLD_SLOPE: old_slope = value & 17'h1ffff;
            CFG_OLD_BASE:  old_base  = value & 17'h1ffff;
            CFG_NEW_SLOPE: new_slope = value & 17'h1ffff;
            CFG_NEW_BASE:  new_base  = value & 17'h1ffff;
            CFG_WIDTH:     dom_w     = value & 19'h7ffff;
            CFG_HEIGHT:    dom_h     = value & 19'h7ffff;
            CFG_WRAP:      wrap_bits = value & 2'h3;
            default:       active_cnt = value & 11'h7ff;
        endcase
    endtask

    function automatic longint any_coord();
        longint v;
        v = $urandom_range(20'hfffff);
        return v >= 524288 ? v - 1048576 : v;
    endfunction

    function automatic longint domain_coord(longint ext);
        if (ext == 0 || $urandom_range(1))
            return any_coord();
        return clamp_to(longint'($urandom_range(int'(ext - 1))), COORD_HI, COORD_LO);
    endfunction

    // Random beats for one register setting: mostly samples, with updates
    // sprinkled so rounds close regularly.
    task automatic run_random_phase(int count);
        center_beat_t none;
        int pick;
        none = '0;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 68)
                issue_command(KIND_SAMPLE, $urandom_range(N_CENTERS - 1),
                              domain_coord(dom_w), domain_coord(dom_h), 0, none);
            else if (pick < 78)
                issue_command(KIND_READ, $urandom_range(N_CENTERS - 1), any_coord(),
                              any_coord(), 0, none);
            else if (pick < 88)
                issue_command(KIND_UPDATE, $urandom_range(N_CENTERS - 1), any_coord(),
                              any_coord(), 0, none);
            else
                issue_command(KIND_LOAD, $urandom_range(N_CENTERS - 1),
                              domain_coord(dom_w), domain_coord(dom_h), 0, none);
            send_idle_pct = beats_in < 220 ? 21 : (beats_in < 420 ? 67 : 0);
        end
    endtask

    task automatic apply_setting(longint os, longint ob, longint ns, longint nb,
                                 longint w, longint h, longint wr, longint act);
        write_register(CFG_OLD_SLOPE, os);
        write_register(CFG_OLD_BASE, ob);
        write_register(CFG_NEW_SLOPE, ns);
        write_register(CFG_NEW_BASE, nb);
        write_register(CFG_WIDTH, w);
        write_register(CFG_HEIGHT, h);
        write_register(CFG_WRAP, wr);
        write_register(CFG_ACTIVE, act);
    endtask

    // Compare every done beat against the oldest expectation.
    always @(posedge clk)
    begin
        center_beat_t want;
        if (rst_n && done)
        begin
            beats_out++;
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected result beat, index %0d", $time, center_index);
                errors++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (want.found) samples_found++;
                centers_moved += want.moved;
                if (center_index !== want.index)
                begin
                    $display("%0t: center_index expected %0d got %0d", $time,
                             want.index, center_index);
                    errors++;
                end
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0d got %0d", $time, want.found, found);
                    errors++;
                end
                if (center_x !== want.cx)
                begin
                    $display("%0t: center_x expected %0d got %0d", $time, want.cx, center_x);
                    errors++;
                end
                if (center_y !== want.cy)
                begin
                    $display("%0t: center_y expected %0d got %0d", $time, want.cy, center_y);
                    errors++;
                end
                if (center_weight !== want.weight)
                begin
                    $display("%0t: center_weight expected %0d got %0d", $time,
                             want.weight, center_weight);
                    errors++;
                end
                if (moved_count !== want.moved)
                begin
                    $display("%0t: moved_count expected %0d got %0d", $time,
                             want.moved, moved_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles in which no beat moves in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        cmd_row_t     dir_rows[14];
        center_beat_t none;
        none = '0;
        old_slope = 32768; old_base = 0; new_slope = 32768; new_base = 65536;
        dom_w = 65536; dom_h = 65536; wrap_bits = 0; active_cnt = 0;
        for (int i = 0; i < N_CENTERS; i++)
        begin
            pos_x[i] = 0; pos_y[i] = 0; acc_x[i] = 0; acc_y[i] = 0;
            hits[i] = 0; rounds[i] = 1;
        end

        // Typed rows: coordinate extremes loaded and read back at weight one,
        // a sample with no active center, an update with nothing hit.
        dir_rows = '{
            '{KIND_LOAD,   10'd0,    20'sh7ffff, -20'sh80000, 1'b1,
              '{10'd0, 1'b0, 20'sd0, 20'sd0, 16'd0, 11'd0}},
            '{KIND_LOAD,   10'd1023, -20'sh80000, 20'sh7ffff, 1'b1,
              '{10'd1023, 1'b0, 20'sd0, 20'sd0, 16'd0, 11'd0}},
            '{KIND_READ,   10'd0,    20'sd0, 20'sd0, 1'b1,
              '{10'd0, 1'b0, 20'sh7ffff, -20'sh80000, 16'd1, 11'd0}},
            '{KIND_READ,   10'd1023, 20'sh7ffff, 20'sh7ffff, 1'b1,
              '{10'd1023, 1'b0, -20'sh80000, 20'sh7ffff, 16'd1, 11'd0}},
            '{KIND_SAMPLE, 10'd5,    20'sh7ffff, -20'sh80000, 1'b1,
              '{10'd0, 1'b0, 20'sd0, 20'sd0, 16'd0, 11'd0}},
            '{KIND_SAMPLE, 10'd0,    -20'sh80000, 20'sh7ffff, 1'b1,
              '{10'd0, 1'b0, 20'sd0, 20'sd0, 16'd0, 11'd0}},
            '{KIND_UPDATE, 10'd0,    20'sd0, 20'sd0, 1'b1,
              '{10'd0, 1'b0, 20'sd0, 20'sd0, 16'd0, 11'd0}},
            '{KIND_LOAD,   10'd2,    20'sd0, 20'sd0, 1'b1,
              '{10'd2, 1'b0, 20'sd0, 20'sd0, 16'd0, 11'd0}},
            '{KIND_READ,   10'd2,    20'sd0, 20'sd0, 1'b1,
              '{10'd2, 1'b0, 20'sd0, 20'sd0, 16'd1, 11'd0}},
            '{KIND_LOAD,   10'd512,  20'sd32768, -20'sd1, 1'b0, '0},
            '{KIND_READ,   10'd512,  20'sd0, 20'sd0, 1'b0, '0},
            '{KIND_LOAD,   10'd0,    20'sd40000, 20'sd20000, 1'b0, '0},
            '{KIND_UPDATE, 10'd1023, 20'sh7ffff, 20'sh7ffff, 1'b0, '0},
            '{KIND_READ,   10'd0,    20'sd0, 20'sd0, 1'b0, '0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue_command(dir_rows[i].kind, dir_rows[i].slot, dir_rows[i].px,
                          dir_rows[i].py, dir_rows[i].typed, dir_rows[i].want);

        // Fill the whole table so any active count stays within written entries.
        for (int i = 0; i < N_CENTERS; i++)
            issue_command(KIND_LOAD, i, domain_coord(65536), domain_coord(65536), 0, none);

        // Directed round with two centers: tie on equal distance, image shift.
        apply_setting(32768, 0, 32768, 65536, 65536, 65536, 3, 2);
        issue_command(KIND_LOAD, 0, 16384, 32768, 0, none);
        issue_command(KIND_LOAD, 1, 49152, 32768, 0, none);
        issue_command(KIND_SAMPLE, 0, 32768, 32768, 0, none);
        issue_command(KIND_SAMPLE, 0, 65000, 1000, 0, none);
        issue_command(KIND_UPDATE, 0, 0, 0, 0, none);
        issue_command(KIND_READ, 0, 0, 0, 0, none);
        issue_command(KIND_READ, 1, 0, 0, 0, none);

        run_random_phase(70);
        apply_setting(65536, 65536, 65536, 65536, 1, 524287, 1, 1);
        run_random_phase(40);
        apply_setting(0, 0, 0, 0, 0, 0, 3, 2);
        run_random_phase(40);
        apply_setting($urandom_range(65536), $urandom_range(65536),
                      $urandom_range(65536), $urandom_range(65536),
                      300000, 70000, 2, 16);
        run_random_phase(80);
        apply_setting(32768, 0, 32768, 65536, 65536, 65536, 3, 2047);
        run_random_phase(15);
        apply_setting(0, 65536, 65536, 0, 524287, 524287, 0, 1024);
        run_random_phase(10);
        apply_setting(32768, 0, 32768, 65536, 65536, 65536, 1, 0);
        run_random_phase(15);
        apply_setting($urandom_range(65536), $urandom_range(65536),
                      $urandom_range(65536), $urandom_range(65536),
                      $urandom_range(1, 524287), $urandom_range(1, 524287),
                      $urandom_range(3), 32);
        run_random_phase(120);
        apply_setting(49152, 16384, 16384, 49152, 131072, 131072, 3, 8);
        run_random_phase(100);
        apply_setting(1, 65535, 65535, 1, 65536, 200000, 2, 64);
        run_random_phase(90);

        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d command beats and %0d result beats over ten settings;",
                 beats_in, beats_out);
        $display("%0d samples found a center, %0d center moves checked.",
                 samples_found, centers_moved);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
